/* src/ftda_pkg.sv */
// ----------------------------------------------------------------------------
// ftda_pkg
// Shared types and constants for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ftda_pkg;

	localparam int INT_BITS   = 32;
	localparam int FRAC_BITS  = 16;
	localparam int VALUE_W    = INT_BITS + FRAC_BITS;
	localparam int DIGITS_W   = 4;
	// decimal digits needed for an unsigned INT_BITS-bit integer
	localparam int INT_DIGITS = (INT_BITS * 30103) / 100000 + 1;
	localparam int BCD_W      = 4 * INT_DIGITS;
	localparam int DIG_IDX_W  = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
	localparam int BIT_CNT_W  = (INT_BITS > 1) ? $clog2(INT_BITS) : 1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [DIGITS_W-1:0]       frac_digits;
	} in_word_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} out_word_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic                  neg;
		logic [INT_BITS-1:0]   ipart;
		logic [FRAC_BITS-1:0]  frac;
		logic [DIGITS_W-1:0]   digits;
	} job_t;

endpackage

`default_nettype wire

/* src/ftda_fifo.sv */
// ----------------------------------------------------------------------------
// ftda_fifo
// Small flop-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module ftda_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      cnt_q <= CNT_W'(cnt_q + 1'b1);
			else if (do_pop && !do_push) cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

`default_nettype wire

/* src/ftda_front.sv */
// ----------------------------------------------------------------------------
// ftda_front
// Classify an incoming word: sign, unsigned magnitude split into integer and
// fraction parts, and the fraction digit count clamped to its maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module ftda_front import ftda_pkg::*; #(
	parameter int MAX_FRAC_DIGITS = 9
) (
	input  wire in_word_t item,
	output job_t          job
);

	logic [VALUE_W-1:0] raw, mag;
	logic               neg;

	assign raw = item.value;
	assign neg = raw[VALUE_W-1];
	// most negative value negates to itself, which is the right magnitude
	assign mag = neg ? VALUE_W'(~raw + 1'b1) : raw;

	always_comb begin
		job.neg    = neg;
		job.ipart  = mag[VALUE_W-1:FRAC_BITS];
		job.frac   = mag[FRAC_BITS-1:0];
		job.digits = (item.frac_digits > DIGITS_W'(MAX_FRAC_DIGITS))
			? DIGITS_W'(MAX_FRAC_DIGITS) : item.frac_digits;
	end

endmodule

`default_nettype wire

/* src/ftda_back.sv */
// ----------------------------------------------------------------------------
// ftda_back
// Sequencer: bit-serial binary to BCD, then one text character per cycle while the output queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module ftda_back import ftda_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job,
	input  wire logic job_empty,
	output logic      job_pop,
	output out_word_t word,
	output logic      word_push,
	input  wire logic word_full
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CONV  = 6'b000010,
		ST_SIGN  = 6'b000100,
		ST_INT   = 6'b001000,
		ST_POINT = 6'b010000,
		ST_FRAC  = 6'b100000
	} state_t;

	state_t                state_q, state_d;
	logic                  neg_q;
	logic [INT_BITS-1:0]   ipart_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [DIGITS_W-1:0]   digits_q;
	logic [BCD_W-1:0]      bcd_q, bcd_adj;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_IDX_W-1:0]  dig_idx_q, lead;
	logic [FRAC_BITS+3:0]  prod;
	logic [3:0]            int_digit;

	// add three to every digit of five or more before the shift
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b);
		logic [3:0] d;
		for (int i = 0; i < INT_DIGITS; i++) begin
			d = b[i*4 +: 4];
			dabble[i*4 +: 4] = (d >= 4'd5) ? 4'(d + 4'd3) : d;
		end
	endfunction

	// index of the most significant nonzero digit, zero if all are zero
	function automatic logic [DIG_IDX_W-1:0] lead_digit(input logic [BCD_W-1:0] b);
		lead_digit = '0;
		for (int i = 0; i < INT_DIGITS; i++) begin
			if (b[i*4 +: 4] != 4'd0) lead_digit = DIG_IDX_W'(i);
		end
	endfunction

	assign bcd_adj   = dabble(bcd_q);
	assign lead      = lead_digit(bcd_q);
	assign int_digit = bcd_q[dig_idx_q*4 +: 4];
	assign prod      = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
	assign job_pop   = (state_q == ST_IDLE) && !job_empty;

	always_comb begin
		word.char_code = CH_ZERO;
		word.last      = 1'b0;
		word_push      = 1'b0;
		state_d        = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!job_empty) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (bit_cnt_q == '0) state_d = ST_SIGN;
			end
			ST_SIGN: begin
				word.char_code = CH_MINUS;
				word_push      = neg_q && !word_full;
				if (!neg_q || !word_full) state_d = ST_INT;
			end
			ST_INT: begin
				word.char_code = CH_ZERO + {4'd0, int_digit};
				word.last      = (dig_idx_q == '0) && (digits_q == '0);
				word_push      = !word_full;
				if (!word_full && dig_idx_q == '0)
					state_d = (digits_q == '0) ? ST_IDLE : ST_POINT;
			end
			ST_POINT: begin
				word.char_code = CH_POINT;
				word_push      = !word_full;
				if (!word_full) state_d = ST_FRAC;
			end
			ST_FRAC: begin
				word.char_code = CH_ZERO + {4'd0, prod[FRAC_BITS+3:FRAC_BITS]};
				word.last      = (digits_q == DIGITS_W'(1));
				word_push      = !word_full;
				if (!word_full && digits_q == DIGITS_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q     <= job.neg;
				ipart_q   <= job.ipart;
				frac_q    <= job.frac;
				digits_q  <= job.digits;
				bcd_q     <= '0;
				bit_cnt_q <= BIT_CNT_W'(INT_BITS - 1);
			end
			ST_CONV: begin
				bcd_q     <= {bcd_adj[BCD_W-2:0], ipart_q[INT_BITS-1]};
				ipart_q   <= {ipart_q[INT_BITS-2:0], 1'b0};
				bit_cnt_q <= BIT_CNT_W'(bit_cnt_q - 1'b1);
			end
			ST_SIGN: begin
				dig_idx_q <= lead;
			end
			ST_INT: begin
				if (!word_full && dig_idx_q != '0)
					dig_idx_q <= DIG_IDX_W'(dig_idx_q - 1'b1);
			end
			ST_POINT: begin
			end
			ST_FRAC: begin
				if (!word_full) begin
					frac_q   <= prod[FRAC_BITS-1:0];
					digits_q <= DIGITS_W'(digits_q - 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/fixed_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii
// Signed fixed-point (32.16) number to decimal ASCII text, one char per word.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  -------   ---------  -------------  --------------------------------------
//  item      in         push / full    value (48b signed), frac_digits (4b)
//  result    out        pop / empty    char_code (8b), last (1b)
//
// Sequence: the back sequencer loads one number, converts its INT_BITS (32)
//   integer bits to BCD bit-serially, passes a set-up step that also carries a
//   leading '-', then emits one further character per cycle while the output
//   queue has room; one number spells out as up to 21 characters.
// Reset: arst_n clears both queues and returns the sequencer to idle.
// Stalls: full rises only when both entries of the two-entry job queue are taken;
//   a withheld pop stalls the sequencer at its current character without losing state.
//
`default_nettype none

module fixed_to_decimal_ascii import ftda_pkg::*; #(
	parameter int MAX_FRAC_DIGITS = 9
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_word_t     result
);

	localparam int JOB_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	job_t      job_in, job_out;
	logic      job_empty, job_pop;
	out_word_t word;
	logic      word_push, word_full;

	// classify the incoming word: sign, magnitude split, clamp digit count
	ftda_front #(
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
	) u_front (
		.item(item),
		.job (job_in)
	);

	// decouple the front from the back so each can stall on its own
	ftda_fifo #(
		.W    ($bits(job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (job_in),
		.full  (full),
		.pop   (job_pop),
		.dout  (job_out),
		.empty (job_empty)
	);

	// convert the integer part and emit the text characters in order
	ftda_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job_out),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.word     (word),
		.word_push(word_push),
		.word_full(word_full)
	);

	// hold finished characters until the consumer pops them
	ftda_fifo #(
		.W    ($bits(out_word_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (word_push),
		.din   (word),
		.full  (word_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

`default_nettype wire

/* src/ftda_checker.sv */
// ----------------------------------------------------------------------------
// ftda_checker
// Port-level assertions for fixed_to_decimal_ascii, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ftda_checker import ftda_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      push,
	input wire logic      full,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_word_t result
);

	// every shown character is a digit, a sign or a point
	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.char_code == CH_MINUS || result.char_code == CH_POINT ||
			(result.char_code >= CH_ZERO && result.char_code <= CH_NINE)))
		else $error("illegal character on result");

	// a waiting word holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while not popped");

	// text never ends on a point
	a_point_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.char_code == CH_POINT |-> !result.last)
		else $error("point flagged as last character");

	// text never ends on a sign
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.char_code == CH_MINUS |-> !result.last)
		else $error("minus flagged as last character");

	// the push and pop handshake inputs are never unknown
	a_push_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(push) && !$isunknown(pop))
		else $error("handshake input unknown");

endmodule

bind fixed_to_decimal_ascii ftda_checker u_ftda_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-point (32.16) to decimal ASCII converter.
// ----------------------------------------------------------------------------
//
// A short directed list covers the value extremes, zero, small negatives,
// saturated digit counts and every digit count. A random list of about 350
// numbers follows, shaped so that integer lengths, signs and fractions vary
// widely. A clocked driver pushes numbers in bursts with random gaps. A
// clocked monitor pops characters on a changing stall pattern, once holding
// off long enough to back the converter up into full. Every accepted number
// is spelled out by a local predictor, and every popped word is compared
// with the oldest expected character.
//
module testbench import ftda_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 4;
	localparam int DIGITS_CAP  = 9;     // fraction digits the converter allows
	localparam int RANDOM_NUMS = 350;
	localparam int HOLD_AT     = 300;   // popped words before the long hold-off
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 120;   // more than the worst case for one number
	localparam int STALL_LIMIT = 5000;  // cycles with no word moving either way

	typedef enum logic [1:0] {
		POP_ALWAYS,
		POP_HALF,
		POP_SPARSE,
		POP_MOSTLY
	} pop_pattern_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_word_t  item   = '0;
	logic      full;
	logic      empty;
	out_word_t result;

	in_word_t  number_queue[$];     // numbers waiting to be offered
	out_word_t expected_chars[$];   // characters predicted, oldest first

	int numbers_taken  = 0;
	int chars_checked  = 0;
	int negatives_seen = 0;
	int capped_counts  = 0;
	int full_stalls    = 0;
	int mismatches     = 0;
	int idle_cycles    = 0;

	fixed_to_decimal_ascii #(
		.MAX_FRAC_DIGITS(DIGITS_CAP)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Spell one number as the converter should: sign, integer digits without
	// leading zeros, then a point and truncated fraction digits.
	function automatic void spell_number(in_word_t word);
		logic                   neg;
		logic [VALUE_W-1:0]     mag;
		logic [INT_BITS-1:0]    whole;
		logic [FRAC_BITS-1:0]   frac;
		logic [FRAC_BITS+3:0]   scaled;
		logic [7:0]             text[$];
		logic [7:0]             int_text[$];
		out_word_t              ch;
		int                     ndig;

		neg = word.value[VALUE_W-1];
		// the most negative value negates onto itself, which reads as 2^47
		mag = neg ? (~word.value + 1'b1) : word.value;
		whole = mag[VALUE_W-1:FRAC_BITS];
		frac = mag[FRAC_BITS-1:0];
		ndig = (word.frac_digits > DIGITS_CAP) ? DIGITS_CAP : int'(word.frac_digits);
		if (word.frac_digits > DIGITS_CAP) capped_counts++;

		if (neg) begin
			text.push_back(CH_MINUS);
			negatives_seen++;
		end
		do begin
			int_text.push_front(CH_ZERO + 8'(whole % 10));
			whole = INT_BITS'(whole / 10);
		end while (whole != 0);
		foreach (int_text[i]) text.push_back(int_text[i]);

		if (ndig > 0) begin
			text.push_back(CH_POINT);
			for (int i = 0; i < ndig; i++) begin
				scaled = (FRAC_BITS + 4)'(frac) * (FRAC_BITS + 4)'(10);
				text.push_back(CH_ZERO + 8'(scaled[FRAC_BITS+3:FRAC_BITS]));
				frac = scaled[FRAC_BITS-1:0];
			end
		end

		foreach (text[i]) begin
			ch.char_code = text[i];
			ch.last = (i == text.size() - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	task automatic queue_number(logic [VALUE_W-1:0] v, int d);
		in_word_t word;

		word.value = v;
		word.frac_digits = DIGITS_W'(d);
		number_queue.push_back(word);
	endtask

	// Driver: offer numbers in bursts, hold an offered word while full is up,
	// and predict each number's text at the edge that takes it.
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		in_word_t next_word;
		logic     offer;

		next_word = '0;
		offer = 1'b0;
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else if (push && full) begin
			// hold the word on the port until the converter takes it
			full_stalls++;
		end else begin
			if (push) begin
				spell_number(item);
				numbers_taken++;
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (number_queue.size() > 0) begin
				next_word = number_queue.pop_front();
				offer = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// a zero gap joins two bursts into one long stretch
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
				end
			end
			push <= offer;
			if (offer) item <= next_word;
		end
	end

	// Monitor: check every popped word against the oldest expected character
	// and pick the next pop from a stall pattern that changes every window.
	pop_pattern_t pop_pattern = POP_ALWAYS;
	int           window_left = 0;
	int           hold_left   = 0;

	always @(posedge clk) begin
		out_word_t want;
		logic      take_next;

		take_next = 1'b0;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected word, char %h last %b", $time,
						result.char_code, result.last);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (result.char_code !== want.char_code) begin
						$display("%0t: char_code expected %h, got %h", $time,
							want.char_code, result.char_code);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$display("%0t: last expected %b, got %b", $time,
							want.last, result.last);
						mismatches++;
					end
				end
				chars_checked++;
				// back the converter up once so that full rises
				if (chars_checked == HOLD_AT) hold_left = HOLD_CYCLES;
			end

			if (window_left == 0) begin
				pop_pattern = pop_pattern_t'($urandom_range(0, 3));
				window_left = $urandom_range(16, 96);
			end else begin
				window_left--;
			end

			if (hold_left > 0) begin
				hold_left--;
			end else begin
				case (pop_pattern)
					POP_ALWAYS: take_next = 1'b1;
					POP_HALF:   take_next = 1'($urandom_range(0, 1));
					POP_SPARSE: take_next = ($urandom_range(0, 3) == 0);
					default:    take_next = ($urandom_range(0, 7) != 0);
				endcase
			end
			pop <= take_next;
		end
	end

	// Watchdog: count cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [63:0]        raw;
		logic [VALUE_W-1:0] v;
		int                 d;

		// directed: zero, extremes, small negatives, capped digit counts
		queue_number('0, 0);
		queue_number('0, 9);
		queue_number({32'd1, 16'h0000}, 3);
		queue_number(-{32'd1, 16'h0000}, 0);
		queue_number(-48'd32768, 1);
		queue_number(-48'd1, 9);
		queue_number(48'd1, 9);
		queue_number({1'b1, 47'd0}, 9);
		queue_number({1'b0, {47{1'b1}}}, 9);
		queue_number({1'b0, {47{1'b1}}}, 0);
		queue_number({1'b1, 47'd0}, 0);
		queue_number(48'h0000_0000_FFFF, 9);
		queue_number({32'd10, 16'h0000}, 2);
		queue_number({32'd9, 16'h8000}, 1);
		queue_number({32'd99, 16'h0000}, 4);
		queue_number({32'd12345, 16'h4000}, 15);
		queue_number('0, 10);
		queue_number(-{32'd1, 16'h0000}, 12);
		queue_number({32'd42, 16'h4000}, 5);
		queue_number({32'd1000000000, 16'h0000}, 6);
		queue_number(-{32'd2147483647, 16'hFFFF}, 7);
		queue_number({32'd100, 16'h0001}, 8);

		// random: full-width values, short integers, values near zero and
		// values of random bit length, each with a random sign
		for (int n = 0; n < RANDOM_NUMS; n++) begin
			raw = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: v = raw[VALUE_W-1:0];
				1: v = {INT_BITS'($urandom_range(0, 99999)), raw[FRAC_BITS-1:0]};
				2: v = VALUE_W'($urandom_range(0, 65535));
				default: v = raw[VALUE_W-1:0] >> $urandom_range(0, VALUE_W - 1);
			endcase
			if ($urandom_range(0, 1)) v = -v;
			d = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
			queue_number(v, d);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every number taken, then every character popped
		while (number_queue.size() != 0 || push) @(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Converted %0d numbers (%0d negative, %0d with capped digit counts)",
			numbers_taken, negatives_seen, capped_counts);
		$display("into %0d characters; push held off by full on %0d cycles",
			chars_checked, full_stalls);
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
